>>> sv/jdqt_pkg.sv
// ----------------------------------------------------------------------------
// JPEG DQT parser package
// Byte codes and limits shared by the quantization table parser.
// ----------------------------------------------------------------------------
package jdqt_pkg;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerDqt    = 8'hDB;
  localparam logic [5:0] EntryLast    = 6'd63;
  localparam logic [7:0] CountMax     = 8'd255;
  localparam logic [15:0] LenHeader   = 16'd2;

  // Parser phase codes.
  localparam logic [2:0] PhScan   = 3'd0;
  localparam logic [2:0] PhMarker = 3'd1;
  localparam logic [2:0] PhLenHi  = 3'd2;
  localparam logic [2:0] PhLenLo  = 3'd3;
  localparam logic [2:0] PhInfo   = 3'd4;
  localparam logic [2:0] PhEntryA = 3'd5;
  localparam logic [2:0] PhEntryB = 3'd6;

endpackage

>>> sv/jpeg_dqt_segment_parser_unit.sv
// ----------------------------------------------------------------------------
// JPEG DQT segment parser unit
// An accepted byte is held in the input register, and its entry result is then
// registered in the result register.
// Throughput: one byte per cycle while out_stall_i does not hold the result register.
// Reset: rst_ni clears the parser to scanning for 0xFF, with all counters
// and both pipeline registers empty.
// ----------------------------------------------------------------------------
module jpeg_dqt_segment_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  table_id_o,
  output logic [3:0]  precision_o,
  output logic [5:0]  entry_index_o,
  output logic [15:0] entry_value_o,
  output logic        last_of_table_o,
  output logic [7:0]  tables_seen_o
);

  // Input register. A byte waits here until the result register can take
  // whatever it produces; the parser state only moves when it is consumed.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state.
  logic [2:0]  phase_q, phase_d;
  logic [15:0] remain_q, remain_d;
  logic [3:0]  cur_prec_q, cur_prec_d;
  logic [3:0]  cur_id_q, cur_id_d;
  logic [5:0]  cur_index_q, cur_index_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic [7:0]  count_q, count_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [3:0]  res_id_q, res_id_d;
  logic [3:0]  res_prec_q, res_prec_d;
  logic [5:0]  res_index_q, res_index_d;
  logic [15:0] res_value_q, res_value_d;
  logic        res_last_q, res_last_d;
  logic [7:0]  res_count_q, res_count_d;

  logic        out_free;
  logic        advance;
  logic        emit;
  logic [15:0] entry_value;
  logic [15:0] remain_dec;
  logic [15:0] seg_len;
  logic        is_last;
  logic [7:0]  count_inc;

  // The result register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Every table byte uses up one byte of segment length, floored at zero.
  assign remain_dec = (remain_q != 16'd0) ? (remain_q - 16'd1) : 16'd0;
  assign seg_len    = {high_byte_q, in_byte_q};
  assign is_last    = (cur_index_q == jdqt_pkg::EntryLast);
  assign count_inc  = (count_q != jdqt_pkg::CountMax) ? (count_q + 8'd1) : count_q;

  always_comb begin
    phase_d     = phase_q;
    remain_d    = remain_q;
    cur_prec_d  = cur_prec_q;
    cur_id_d    = cur_id_q;
    cur_index_d = cur_index_q;
    high_byte_d = high_byte_q;
    count_d     = count_q;
    emit        = 1'b0;
    entry_value = {8'd0, in_byte_q};

    unique case (phase_q)
      jdqt_pkg::PhMarker: begin
        phase_d = (in_byte_q == jdqt_pkg::MarkerDqt) ? jdqt_pkg::PhLenHi
                                                     : jdqt_pkg::PhScan;
      end
      jdqt_pkg::PhLenHi: begin
        high_byte_d = in_byte_q;
        phase_d     = jdqt_pkg::PhLenLo;
      end
      jdqt_pkg::PhLenLo: begin
        // A length of at most the two header bytes leaves nothing to parse.
        if (seg_len > jdqt_pkg::LenHeader) begin
          remain_d = seg_len - jdqt_pkg::LenHeader;
          phase_d  = jdqt_pkg::PhInfo;
        end else begin
          remain_d = 16'd0;
          phase_d  = jdqt_pkg::PhScan;
        end
      end
      jdqt_pkg::PhInfo: begin
        cur_prec_d  = in_byte_q[7:4];
        cur_id_d    = in_byte_q[3:0];
        cur_index_d = 6'd0;
        remain_d    = remain_dec;
        phase_d     = jdqt_pkg::PhEntryA;
      end
      jdqt_pkg::PhEntryA: begin
        remain_d = remain_dec;
        if (cur_prec_q == 4'd0) begin
          emit = 1'b1;
        end else begin
          high_byte_d = in_byte_q;
          phase_d     = jdqt_pkg::PhEntryB;
        end
      end
      jdqt_pkg::PhEntryB: begin
        remain_d    = remain_dec;
        emit        = 1'b1;
        entry_value = {high_byte_q, in_byte_q};
      end
      default: begin
        phase_d = (in_byte_q == jdqt_pkg::MarkerPrefix) ? jdqt_pkg::PhMarker
                                                        : jdqt_pkg::PhScan;
      end
    endcase

    // Finishing an entry steps the index, and after entry 63 either starts
    // another table or drops back to scanning once the length is used up.
    if (emit) begin
      if (is_last) begin
        count_d     = count_inc;
        cur_index_d = 6'd0;
        phase_d     = (remain_dec != 16'd0) ? jdqt_pkg::PhInfo : jdqt_pkg::PhScan;
      end else begin
        cur_index_d = cur_index_q + 6'd1;
        phase_d     = jdqt_pkg::PhEntryA;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_id_d    = res_id_q;
    res_prec_d  = res_prec_q;
    res_index_d = res_index_q;
    res_value_d = res_value_q;
    res_last_d  = res_last_q;
    res_count_d = res_count_q;
    if (advance) begin
      out_valid_d = emit;
      res_id_d    = cur_id_q;
      res_prec_d  = cur_prec_q;
      res_index_d = cur_index_q;
      res_value_d = entry_value;
      res_last_d  = is_last;
      res_count_d = is_last ? count_inc : count_q;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= jdqt_pkg::PhScan;
      remain_q    <= 16'd0;
      cur_prec_q  <= 4'd0;
      cur_id_q    <= 4'd0;
      cur_index_q <= 6'd0;
      high_byte_q <= 8'd0;
      count_q     <= 8'd0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q     <= phase_d;
        remain_q    <= remain_d;
        cur_prec_q  <= cur_prec_d;
        cur_id_q    <= cur_id_d;
        cur_index_q <= cur_index_d;
        high_byte_q <= high_byte_d;
        count_q     <= count_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
    res_id_q    <= res_id_d;
    res_prec_q  <= res_prec_d;
    res_index_q <= res_index_d;
    res_value_q <= res_value_d;
    res_last_q  <= res_last_d;
    res_count_q <= res_count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign table_id_o      = res_id_q;
  assign precision_o     = res_prec_q;
  assign entry_index_o   = res_index_q;
  assign entry_value_o   = res_value_q;
  assign last_of_table_o = res_last_q;
  assign tables_seen_o   = res_count_q;

endmodule
